>>> design/checksummed_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// Checksummed frame receiver assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH
`define CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication.
`define CFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> design/cfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants of the checksummed frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

	// Frames longer than this get a too-long verdict (range 4 to 255).
	localparam logic [7:0] MAX_FRAME_LEN = 8'd255;
	localparam logic [7:0] CHECK_BASE    = 8'hFF;

	typedef enum logic {
		OP_BYTE  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_WRONG_ID  = 3'd1,
		ST_CHECKSUM  = 3'd2,
		ST_TOO_SHORT = 3'd3,
		ST_TOO_LONG  = 3'd4
	} status_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] frame_byte;
		logic       is_last;
	} byte_req_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload;
		logic [7:0] frame_number;
		status_t    status;
		logic [7:0] quantity;
		logic       frame_done;
	} result_t;

endpackage
`default_nettype wire

>>> design/checksummed_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a byte accepted into the input register is parsed from there; its
//   result (if any) is registered into the output register (res_*) or the skid entry.
// Throughput: one byte per cycle while the skid is free (combinational parse and update).
// Backpressure: a two-deep output (result register plus skid) keeps input flowing.
// Reset: arst_n clears the session, the frame in progress and all valid flags.
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// Parses id / number / quantity / payload / checksum frames byte by byte,
// streams payload bytes and closes each frame with a status verdict.
// ----------------------------------------------------------------------------
`include "checksummed_frame_receiver_macros.svh"

module checksummed_frame_receiver
	import cfr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	// incoming frame bytes
	input  wire logic      byte_valid,
	output logic           byte_stall,
	input  wire byte_req_t byte_data,
	// outgoing results
	output logic           res_valid,
	input  wire logic      res_stall,
	output result_t        res_data
);

	// ------------------------------------------------------------------
	// Input register: one request waits here for the parse.
	// ------------------------------------------------------------------
	logic      valid_s1;
	byte_req_t item_s1;

	// Output register and skid entry.
	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	// Session and frame state.
	logic [7:0] pos_q;      // index of the next byte in the frame, saturating
	logic [7:0] sid_q;      // latched id, zero = none
	logic       mism_q;     // current frame carries a foreign id
	logic [7:0] num_q;      // frame number of the current frame
	logic [7:0] sum_q;      // running byte sum after the id
	logic [7:0] pq_q;       // quantity byte of the current frame
	logic [7:0] tot_q;      // committed quantity

	logic accept;
	logic fire;
	logic out_taken;

	// The parse stage moves on whenever the skid entry is free; the skid
	// then always has room for whatever the parse produces.
	assign fire       = valid_s1 && !skid_valid_q;
	assign byte_stall = valid_s1 && skid_valid_q;
	assign accept     = byte_valid && !byte_stall;
	assign out_taken  = out_valid_q && !res_stall;

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// ------------------------------------------------------------------
	// Parse: next state and the result of the request in item_s1.
	// ------------------------------------------------------------------
	logic [7:0] b;
	logic       first;
	logic [7:0] pos_n, sid_n, num_n, sum_n, pq_n, tot_n;
	logic       mism_n;
	logic       emit;
	result_t    res_n;
	status_t    verdict;

	assign b     = item_s1.frame_byte;
	assign first = (pos_q == 8'd0);

	always_comb begin
		// Start-of-frame reload, id latch and id check.
		num_n  = first ? 8'd0 : num_q;
		sum_n  = first ? 8'd0 : sum_q;
		pq_n   = first ? 8'd0 : pq_q;
		mism_n = first ? ((sid_q != 8'd0) && (sid_q != b)) : mism_q;
		sid_n  = (first && (sid_q == 8'd0)) ? b : sid_q;
		tot_n  = tot_q;
		pos_n  = pos_q;
		emit   = 1'b0;
		verdict = ST_OK;

		res_n.kind         = KIND_PAYLOAD;
		res_n.payload      = b;
		res_n.frame_number = 8'd0;
		res_n.status       = ST_OK;
		res_n.quantity     = 8'd0;
		res_n.frame_done   = 1'b0;

		if (item_s1.op == OP_CLEAR) begin
			// Clear: whole session back to reset, nothing emitted.
			pos_n  = 8'd0;
			sid_n  = 8'd0;
			mism_n = 1'b0;
			num_n  = 8'd0;
			sum_n  = 8'd0;
			pq_n   = 8'd0;
			tot_n  = 8'd0;
		end else if (!item_s1.is_last) begin
			if (pos_q >= 8'd1) begin
				sum_n = sum_n + b;
			end
			if (pos_q == 8'd1) begin
				num_n = b;
			end else if (pos_q >= 8'd2) begin
				if ((pos_q == 8'd2) && (num_n == 8'd0)) begin
					// Quantity byte of frame zero, held until the verdict.
					pq_n = b;
				end else if (!mism_n && (pos_q < MAX_FRAME_LEN)) begin
					emit = 1'b1;
				end
			end
			pos_n = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
		end else begin
			// Checksum byte: verdict in priority order.
			if (mism_n) begin
				verdict = ST_WRONG_ID;
			end else if ((pos_q < 8'd2) || ((pos_q == 8'd2) && (num_n == 8'd0))) begin
				verdict = ST_TOO_SHORT;
			end else if (pos_q >= MAX_FRAME_LEN) begin
				verdict = ST_TOO_LONG;
			end else if ((CHECK_BASE - sum_n) != b) begin
				verdict = ST_CHECKSUM;
			end else begin
				verdict = ST_OK;
				tot_n   = pq_n;
			end
			emit             = 1'b1;
			res_n.kind       = KIND_VERDICT;
			res_n.payload    = 8'd0;
			res_n.status     = verdict;
			res_n.frame_done = 1'b1;
			pos_n  = 8'd0;
			sum_n  = 8'd0;
			mism_n = 1'b0;
		end

		res_n.frame_number = num_n;
		res_n.quantity     = tot_n;
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			pos_q        <= 8'd0;
			sid_q        <= 8'd0;
			mism_q       <= 1'b0;
			num_q        <= 8'd0;
			sum_q        <= 8'd0;
			pq_q         <= 8'd0;
			tot_q        <= 8'd0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end

			if (fire) begin
				pos_q  <= pos_n;
				sid_q  <= sid_n;
				mism_q <= mism_n;
				num_q  <= num_n;
				sum_q  <= sum_n;
				pq_q   <= pq_n;
				tot_q  <= tot_n;
			end

			// Output pair; skid is empty whenever the parse fires.
			if (fire && emit) begin
				if (!out_valid_q || !res_stall) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_taken) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_data;
		end
		if (fire && emit) begin
			if (!out_valid_q || !res_stall) begin
				out_q <= res_n;
			end else begin
				skid_q <= res_n;
			end
		end else if (out_taken && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`CFR_ASSERT_NOW(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`CFR_ASSERT_NEXT(a_verdict_ends_frame, clk, arst_n,
		fire && (item_s1.op == OP_BYTE) && item_s1.is_last,
		(pos_q == 8'd0) && !mism_q && (sum_q == 8'd0))
	`CFR_ASSERT_NEXT(a_clear_forgets, clk, arst_n,
		fire && (item_s1.op == OP_CLEAR),
		(sid_q == 8'd0) && (tot_q == 8'd0) && (pos_q == 8'd0))

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_receiver testbench
// Streams directed and random frame bytes into the receiver, predicts the
// payload and verdict results in a scoreboard, and checks them in order
// while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import cfr_pkg::*;

	// Scoreboard: tracks the receiver's parse state and queues the results
	// each accepted request should produce.
	class frame_receiver_model;
		logic [7:0] byte_pos;
		logic [7:0] sess_id;
		logic       id_bad;
		logic [7:0] frame_num;
		logic [7:0] run_sum;
		logic [7:0] pend_qty;
		logic [7:0] total_qty;
		result_t    awaited[$];
		int         errors;

		function new();
			errors = 0;
			clear_session();
		endfunction

		function void clear_session();
			byte_pos  = '0;
			sess_id   = '0;
			id_bad    = 1'b0;
			frame_num = '0;
			run_sum   = '0;
			pend_qty  = '0;
			total_qty = '0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void take_request(byte_req_t rq);
			logic [7:0] pos;
			logic [7:0] b;
			logic [7:0] want_sum;
			status_t    st;
			result_t    r;
			pos = byte_pos;
			b   = rq.frame_byte;
			if (rq.op == OP_CLEAR) begin
				clear_session();
				return;
			end
			// id byte opens a new frame; zero in the session means nothing latched
			if (pos == 8'd0) begin
				frame_num = '0;
				run_sum   = '0;
				pend_qty  = '0;
				id_bad    = 1'b0;
				if (sess_id == 8'd0)
					sess_id = b;
				else if (sess_id != b)
					id_bad = 1'b1;
			end
			r.frame_done = 1'b0;
			r.status     = ST_OK;
			if (!rq.is_last) begin
				if (pos == 8'd1) begin
					frame_num = b;
					run_sum   = run_sum + b;
				end else if (pos >= 8'd2) begin
					run_sum = run_sum + b;
					if (pos == 8'd2 && frame_num == 8'd0) begin
						pend_qty = b;
					end else if (!id_bad && pos < MAX_FRAME_LEN) begin
						r.kind         = KIND_PAYLOAD;
						r.payload      = b;
						r.frame_number = frame_num;
						r.quantity     = total_qty;
						awaited.push_back(r);
					end
				end
				if (pos != 8'hff)
					byte_pos = pos + 8'd1;
				return;
			end
			// checksum byte: verdict in priority order
			want_sum = CHECK_BASE - run_sum;
			if (id_bad)
				st = ST_WRONG_ID;
			else if (pos < 8'd2 || (pos == 8'd2 && frame_num == 8'd0))
				st = ST_TOO_SHORT;
			else if (pos >= MAX_FRAME_LEN)
				st = ST_TOO_LONG;
			else if (want_sum != b)
				st = ST_CHECKSUM;
			else begin
				st        = ST_OK;
				total_qty = pend_qty;
			end
			r.kind         = KIND_VERDICT;
			r.payload      = '0;
			r.frame_number = frame_num;
			r.status       = st;
			r.quantity     = total_qty;
			r.frame_done   = 1'b1;
			awaited.push_back(r);
			byte_pos = '0;
			run_sum  = '0;
			id_bad   = 1'b0;
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected kind=%0d pay=%02h num=%02h st=%0d qty=%02h done=%0d",
					$time, got.kind, got.payload, got.frame_number, got.status,
					got.quantity, got.frame_done);
				return;
			end
			want = awaited.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: expected kind=%0d pay=%02h num=%02h st=%0d qty=%02h done=%0d",
					$time, want.kind, want.payload, want.frame_number, want.status,
					want.quantity, want.frame_done);
				$display("%0t:   actual kind=%0d pay=%02h num=%02h st=%0d qty=%02h done=%0d",
					$time, got.kind, got.payload, got.frame_number, got.status,
					got.quantity, got.frame_done);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	byte_req_t byte_data  = '0;
	logic      res_valid;
	logic      res_stall  = 1'b0;
	result_t   res_data;

	frame_receiver_model model = new();

	// quiet: both sides run without idling for the current phase
	bit quiet    = 1'b0;
	// hold_req: one-shot request for a long receiver stall, in cycles
	int hold_req = 0;
	int sent     = 0;

	checksummed_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well past the slowest legal run (~750 bytes, each waiting
	// out a full gap on both sides, plus the long hold and the drains).
	initial begin
		#5_000_000;
		$display("checksummed_frame_receiver: mismatch");
		$finish;
	end

	// Result side. Samples right after the edge, so values are the pre-edge
	// ones; after every accepted result it draws a fresh random stall, or
	// takes a long hold when the stimulus asks for one.
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				model.match_result(res_data);
				stall_left = quiet ? 0 : $urandom_range(0, 15);
			end
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req   = 0;
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// One request: optional idle gap, then hold valid and payload until the
	// edge where stall is low. valid stays high into the next request when
	// that one draws no gap.
	task automatic send_byte(input op_t op, input logic [7:0] b, input logic last);
		byte_req_t rq;
		int        gap;
		rq.op         = op;
		rq.frame_byte = b;
		rq.is_last    = last;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= rq;
		do @(posedge clk); while (byte_stall);
		model.take_request(rq);
		sent++;
	endtask

	// Well-formed frame with random payload; bad_sum flips one checksum bit.
	task automatic send_frame(input logic [7:0] id, input logic [7:0] num,
			input logic [7:0] qty, input int npay, input bit bad_sum);
		logic [7:0] sum;
		logic [7:0] pb;
		sum = num;
		send_byte(OP_BYTE, id, 1'b0);
		send_byte(OP_BYTE, num, 1'b0);
		if (num == 8'd0) begin
			sum = sum + qty;
			send_byte(OP_BYTE, qty, 1'b0);
		end
		repeat (npay) begin
			pb  = 8'($urandom);
			sum = sum + pb;
			send_byte(OP_BYTE, pb, 1'b0);
		end
		sum = CHECK_BASE - sum;
		if (bad_sum)
			sum = sum ^ (8'd1 << $urandom_range(0, 7));
		send_byte(OP_BYTE, sum, 1'b1);
	endtask

	// Mostly well-formed frames under the latched id; the rest are foreign
	// ids, truncated frames, byte noise and session clears.
	task automatic random_item();
		int         pick;
		int         n;
		logic [7:0] id;
		logic [7:0] num;
		pick = $urandom_range(0, 99);
		id   = model.sess_id;
		if (id == 8'd0)
			id = 8'($urandom);
		num = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		if (pick < 70) begin
			send_frame(id, num, 8'($urandom), $urandom_range(0, 10),
				$urandom_range(0, 6) == 0);
		end else if (pick < 78) begin
			send_frame(8'($urandom), num, 8'($urandom), $urandom_range(0, 6),
				$urandom_range(0, 3) == 0);
		end else if (pick < 86) begin
			// checksum lands on byte one, two, or three with frame number 0
			n = $urandom_range(1, 3);
			send_byte(OP_BYTE, id, n == 1);
			if (n >= 2)
				send_byte(OP_BYTE, (n == 3) ? 8'd0 : 8'($urandom), n == 2);
			if (n == 3)
				send_byte(OP_BYTE, 8'($urandom), 1'b1);
		end else if (pick < 94) begin
			n = $urandom_range(1, 8);
			for (int k = 0; k < n; k++)
				send_byte(OP_BYTE, 8'($urandom), (k == n - 1) || ($urandom_range(0, 7) == 0));
		end else begin
			send_byte(OP_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)));
		end
	endtask

	// Sender pause: stop offering, wait out every pending result, and then
	// let the two-stage result path settle before going on.
	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (model.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed ----
		// clear with every other field high
		send_byte(OP_CLEAR, 8'hff, 1'b1);
		// id of zero latches nothing
		send_frame(8'h00, 8'h05, 8'h00, 1, 1'b0);
		// frame number 0: quantity byte committed on ok
		send_frame(8'hA5, 8'h00, 8'hff, 1, 1'b0);
		// foreign id: verdict only, no payload
		send_frame(8'h5A, 8'h01, 8'h00, 1, 1'b0);
		// too short: checksum as first, second, and third byte with number 0
		send_byte(OP_BYTE, 8'hA5, 1'b1);
		send_byte(OP_BYTE, 8'hA5, 1'b0);
		send_byte(OP_BYTE, 8'h7e, 1'b1);
		send_byte(OP_BYTE, 8'hA5, 1'b0);
		send_byte(OP_BYTE, 8'h00, 1'b0);
		send_byte(OP_BYTE, 8'h81, 1'b1);
		// checksum error with the top frame number
		send_frame(8'hA5, 8'hff, 8'h00, 1, 1'b1);
		// clear forgets id and quantity; next frame latches anew
		send_byte(OP_CLEAR, 8'h00, 1'b0);
		send_frame(8'h3C, 8'h80, 8'h00, 0, 1'b0);
		wait_drained();

		// ---- random phases ----
		target = sent;
		for (int phase = 0; phase < 8; phase++) begin
			quiet  = (phase % 3 == 2);
			target = target + 18;
			if (phase == 3) begin
				// long receiver hold while requests keep coming: the result
				// buffer fills and the input stalls
				hold_req = 400;
			end
			if (phase == 5) begin
				// frame length around the limit: last fit, then too long with
				// the byte counter held at its saturated top value
				send_frame(model.sess_id, 8'($urandom_range(1, 255)), 8'd0, 252, 1'b0);
				send_frame(model.sess_id, 8'($urandom_range(1, 255)), 8'd0, 256, 1'b0);
				target = sent + 18;
			end
			while (sent < target)
				random_item();
			wait_drained();
		end

		quiet = 1'b0;
		repeat (20) @(posedge clk);
		if (model.errors == 0 && model.pending() == 0)
			$display("checksummed_frame_receiver: match");
		else
			$display("checksummed_frame_receiver: mismatch");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+design
design/cfr_pkg.sv
design/checksummed_frame_receiver.sv
tb/testbench.sv
